// ----- src/assert_macros.svh -----
// Assertion helper macros for the reassembly table checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- src/csrt_pkg.sv -----
// ----------------------------------------------------------------------------
// csrt_pkg
// Shared types and codes of the SMS reassembly table.
// ----------------------------------------------------------------------------
package csrt_pkg;

  localparam int unsigned ReqW = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_STORE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_STORED    = 4'd0,
    ST_WAITING   = 4'd1,
    ST_COMPLETE  = 4'd2,
    ST_BAD_TOTAL = 4'd3,
    ST_BAD_PART  = 4'd4,
    ST_NO_SLOT   = 4'd5,
    ST_TOO_LONG  = 4'd6,
    ST_READ      = 4'd7,
    ST_RELEASED  = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_SUM,
    CS_OUT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the input beat
    logic execute;   // decode, update tables, write or read payload
    logic sum_step;  // accumulate one part length
    logic out_load;  // move the result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;      // request returns no result
    logic need_sum;  // completion reached, lengths must be added
    logic sum_done;  // current step adds the last length
  } dp_sts_t;

endpackage

// ----- src/csrt_datapath.sv -----
// ----------------------------------------------------------------------------
// csrt_datapath
// Slot tables, part lengths, payload memory and the result register.
// ----------------------------------------------------------------------------
module csrt_datapath #(
  parameter int unsigned NUM_SLOTS  = 4,
  parameter int unsigned MAX_PARTS  = 7,
  parameter int unsigned PART_BYTES = 640
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csrt_pkg::dp_cmd_t cmd_i,
  output csrt_pkg::dp_sts_t sts_o,
  input  logic [1:0]        req_type_i,
  input  logic [15:0]       msg_ref_i,
  input  logic [7:0]        msg_tot_i,
  input  logic [7:0]        msg_seg_i,
  input  logic [9:0]        byte_offset_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_of_segment_i,
  input  logic [1:0]        slot_sel_i,
  output logic [3:0]        status_o,
  output logic [1:0]        slot_out_o,
  output logic [12:0]       total_len_o,
  output logic [6:0]        seg_bitmap_o,
  output logic [7:0]        data_out_o
);
  import csrt_pkg::*;

  localparam int unsigned SlotW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned PartW  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned NumLen = NUM_SLOTS * MAX_PARTS;
  localparam int unsigned LenIdxW = (NumLen > 1) ? $clog2(NumLen) : 1;
  localparam int unsigned Depth  = NumLen * PART_BYTES;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LenW   = $clog2(PART_BYTES + 1);

  // captured beat
  logic [1:0]  req_q;
  logic [15:0] ref_q;
  logic [7:0]  tot_q, seg_q, data_q;
  logic [9:0]  off_q;
  logic        last_q;
  logic [1:0]  sel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      ref_q  <= msg_ref_i;
      tot_q  <= msg_tot_i;
      seg_q  <= msg_seg_i;
      off_q  <= byte_offset_i;
      data_q <= data_byte_i;
      last_q <= last_of_segment_i;
      sel_q  <= slot_sel_i;
    end
  end

  // slot tables
  logic [15:0]        slot_ref_q  [NUM_SLOTS];
  logic [7:0]         slot_tot_q  [NUM_SLOTS];
  logic [MAX_PARTS-1:0] present_q [NUM_SLOTS];
  logic [LenW-1:0]    part_len_q  [NumLen];

  // slot search
  logic             hit_found, free_found, slot_found;
  logic [SlotW-1:0] hit_idx, free_idx, slot_idx;
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (slot_tot_q[s] != 8'd0 && slot_ref_q[s] == ref_q && slot_tot_q[s] == tot_q) begin
        hit_found = 1'b1;
        hit_idx   = SlotW'(s);
      end
      if (slot_tot_q[s] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = SlotW'(s);
      end
    end
    slot_found = hit_found | free_found;
    slot_idx   = hit_found ? hit_idx : free_idx;
  end

  logic bad_tot, bad_seg, too_long, rd_bad_seg, sel_bad;
  assign bad_tot    = (tot_q == 8'd0) || (32'(tot_q) > MAX_PARTS);
  assign bad_seg    = (seg_q == 8'd0) || (seg_q > tot_q);
  assign too_long   = 32'(off_q) >= PART_BYTES;
  assign rd_bad_seg = (seg_q == 8'd0) || (32'(seg_q) > MAX_PARTS);
  assign sel_bad    = 32'(sel_q) >= NUM_SLOTS;

  logic [PartW-1:0] part_idx;
  assign part_idx = PartW'(seg_q - 8'd1);

  logic [SlotW-1:0] sel_idx;
  assign sel_idx = SlotW'(sel_q);

  logic [SlotW-1:0] addr_slot;
  assign addr_slot = (req_e'(req_q) == REQ_STORE) ? slot_idx : sel_idx;

  logic [LenIdxW-1:0] len_idx;
  assign len_idx = LenIdxW'(32'(addr_slot) * MAX_PARTS + 32'(part_idx));

  logic [AddrW-1:0] mem_addr;
  assign mem_addr = AddrW'(32'(len_idx) * PART_BYTES + 32'(off_q));

  logic store_ok;
  assign store_ok = (req_e'(req_q) == REQ_STORE) && !bad_tot && !bad_seg &&
                    !too_long && slot_found;

  logic [MAX_PARTS-1:0] present_new, need_mask;
  always_comb begin
    present_new = present_q[slot_idx];
    if (last_q) present_new[part_idx] = 1'b1;
    need_mask = '0;
    for (int p = 0; p < MAX_PARTS; p++)
      if (p < 32'(tot_q)) need_mask[p] = 1'b1;
  end

  // result staging
  logic [3:0]       st_q;
  logic [SlotW-1:0] rslot_q;
  logic [6:0]       map_q;
  logic             drop_q, need_q;
  logic [PartW-1:0] cnt_q;
  logic [12:0]      sum_q;
  logic [7:0]       mem_rd_q;
  logic             rd_sel_q;

  logic [3:0]       st_d;
  logic [SlotW-1:0] rslot_d;
  logic [6:0]       map_d;
  logic             rd_sel_d;

  // payload memory
  logic [7:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && store_ok) mem[mem_addr] <= data_q;
    mem_rd_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_ref_q[s] <= '0;
        slot_tot_q[s] <= '0;
        present_q[s]  <= '0;
      end
      for (int i = 0; i < NumLen; i++) part_len_q[i] <= '0;
      drop_q <= 1'b0;
      need_q <= 1'b0;
    end else if (cmd_i.execute) begin
      drop_q <= (req_e'(req_q) == REQ_NONE);
      need_q <= store_ok && last_q && ((present_new & need_mask) == need_mask);
      if (store_ok) begin
        if (!hit_found) begin
          slot_tot_q[slot_idx] <= tot_q;
          slot_ref_q[slot_idx] <= ref_q;
        end
        if (last_q) begin
          part_len_q[len_idx]  <= LenW'(32'(off_q) + 1);
          present_q[slot_idx]  <= present_new;
        end
      end else if (req_e'(req_q) == REQ_RELEASE && !sel_bad) begin
        slot_ref_q[sel_idx] <= '0;
        slot_tot_q[sel_idx] <= '0;
        present_q[sel_idx]  <= '0;
        for (int p = 0; p < MAX_PARTS; p++)
          part_len_q[LenIdxW'(32'(sel_idx) * MAX_PARTS + p)] <= '0;
      end
    end
  end

  always_comb begin
    st_d     = ST_STORED;
    rslot_d  = '0;
    map_d    = '0;
    rd_sel_d = 1'b0;
    unique case (req_e'(req_q))
      REQ_STORE: begin
        if (bad_tot)          st_d = ST_BAD_TOTAL;
        else if (bad_seg)     st_d = ST_BAD_PART;
        else if (too_long)    st_d = ST_TOO_LONG;
        else if (!slot_found) st_d = ST_NO_SLOT;
        else begin
          rslot_d = slot_idx;
          st_d    = last_q ? ST_WAITING : ST_STORED;
          map_d   = last_q ? 7'(present_new) : 7'(present_q[slot_idx]);
        end
      end
      REQ_READ: begin
        if (rd_bad_seg)    st_d = ST_BAD_PART;
        else if (too_long) st_d = ST_TOO_LONG;
        else if (sel_bad)  st_d = ST_NO_SLOT;
        else begin
          st_d     = ST_READ;
          rslot_d  = sel_idx;
          map_d    = 7'(present_q[sel_idx]);
          rd_sel_d = 1'b1;
        end
      end
      REQ_RELEASE: begin
        if (sel_bad) st_d = ST_NO_SLOT;
        else begin
          st_d    = ST_RELEASED;
          rslot_d = sel_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      rd_sel_q <= rd_sel_d;
      rslot_q  <= rslot_d;
      map_q    <= map_d;
      st_q     <= st_d;
    end else if (cmd_i.sum_step) begin
      // add one part length, saturate at the field maximum
      sum_q <= (14'(sum_q) + 14'(part_len_q[LenIdxW'(32'(rslot_q) * MAX_PARTS
               + 32'(cnt_q))]) > 14'd8191) ? 13'h1FFF
               : 13'(sum_q + 13'(part_len_q[LenIdxW'(32'(rslot_q) * MAX_PARTS
               + 32'(cnt_q))]));
      cnt_q <= cnt_q + PartW'(1);
      st_q  <= ST_COMPLETE;
    end
  end

  logic [7:0] tot_cap_q;
  always_ff @(posedge clk_i) if (cmd_i.execute) tot_cap_q <= tot_q;

  assign sts_o.drop     = drop_q;
  assign sts_o.need_sum = need_q;
  assign sts_o.sum_done = (32'(cnt_q) + 1) >= 32'(tot_cap_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o     <= st_q;
      slot_out_o   <= 2'(rslot_q);
      total_len_o  <= (st_q == ST_COMPLETE) ? sum_q : 13'd0;
      seg_bitmap_o <= map_q;
      data_out_o   <= rd_sel_q ? mem_rd_q : 8'd0;
    end
  end

endmodule

// ----- src/csrt_ctrl.sv -----
// ----------------------------------------------------------------------------
// csrt_ctrl
// Sequencer: capture, execute, optional length sum, output handshake.
// ----------------------------------------------------------------------------
module csrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output csrt_pkg::dp_cmd_t cmd_o,
  input  csrt_pkg::dp_sts_t sts_i
);
  import csrt_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        ovalid_q, ovalid_d;
  logic        out_free;

  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: if (in_valid_i) state_d = CS_EXEC;
      CS_EXEC: state_d = CS_SUM;
      CS_SUM: begin
        if (sts_i.drop) state_d = CS_IDLE;
        else if (!sts_i.need_sum || sts_i.sum_done) state_d = CS_OUT;
      end
      CS_OUT: if (out_free) state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    ovalid_d   = ovalid_q && out_stall_i;
    unique case (state_q)
      CS_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = 1'b1;
      end
      CS_EXEC: cmd_o.execute = 1'b1;
      CS_SUM:  cmd_o.sum_step = sts_i.need_sum;
      CS_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= CS_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

// ----- src/concat_sms_reassembly_table.sv -----
// ----------------------------------------------------------------------------
// concat_sms_reassembly_table
// Multi-part SMS reassembly: slot match, payload store, completion report.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with one request per beat (store,
// read or release). Output channel: out_valid_o / out_stall_i, one result per
// request; request type 3 gives none.
// One request at a time: capture, execute (table update and payload memory
// access), a sum state that adds the part lengths one per step when the
// request completes a message, then the output register. The next request is
// accepted only after the current one has left the sum and output states;
// throughput is set by the single sequencer and the one-port payload memory.
// Reset clears the slot tables and part lengths at once; payload memory is
// not cleared. A stalled result holds in the output register; the next
// request is still accepted, and its result waits until that register is
// free, with the input stalled meanwhile.
// ----------------------------------------------------------------------------
module concat_sms_reassembly_table #(
  parameter int unsigned NUM_SLOTS  = 4,
  parameter int unsigned MAX_PARTS  = 7,
  parameter int unsigned PART_BYTES = 640
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] msg_ref_i,
  input  logic [7:0]  msg_tot_i,
  input  logic [7:0]  msg_seg_i,
  input  logic [9:0]  byte_offset_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_segment_i,
  input  logic [1:0]  slot_sel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [1:0]  slot_out_o,
  output logic [12:0] total_len_o,
  output logic [6:0]  seg_bitmap_o,
  output logic [7:0]  data_out_o
);
  import csrt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  csrt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  csrt_datapath #(
    .NUM_SLOTS(NUM_SLOTS), .MAX_PARTS(MAX_PARTS), .PART_BYTES(PART_BYTES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i, .msg_ref_i, .msg_tot_i, .msg_seg_i, .byte_offset_i,
    .data_byte_i, .last_of_segment_i, .slot_sel_i,
    .status_o, .slot_out_o, .total_len_o, .seg_bitmap_o, .data_out_o
  );

endmodule

// ----- src/csrt_checker.sv -----
// ----------------------------------------------------------------------------
// csrt_checker
// Port-level checks of the reassembly table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module csrt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  status_o,
  input logic [12:0] total_len_o,
  input logic [7:0]  data_out_o
);
  import csrt_pkg::*;

  `ASSERT_IMPL(a_len_only_complete, clk_i, rst_ni,
    out_valid_o && status_o != ST_COMPLETE, total_len_o == 13'd0)
  `ASSERT_IMPL(a_data_only_read, clk_i, rst_ni,
    out_valid_o && status_o != ST_READ, data_out_o == 8'd0)
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni,
    in_valid_i && !in_stall_o, in_stall_o)
  `ASSERT_NEXT(a_out_holds, clk_i, rst_ni,
    out_valid_o && out_stall_i, out_valid_o && $stable(status_o))
endmodule

bind concat_sms_reassembly_table csrt_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .total_len_o, .data_out_o
);
